### design/assert_macros.svh
// Concurrent assertion helpers used by the checker file rqi_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante holds in a cycle -> cons holds in the same cycle
`define RQI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante holds in a cycle -> cons holds in the next cycle
`define RQI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/rqi_pkg.sv
`timescale 1ns / 1ps
package rqi_pkg;

    localparam int W         = 32;
    localparam int F         = 16;
    localparam int PW        = 2 * W;
    localparam int WIDE      = 2 * W + 2;
    localparam int DIV_STEPS = W + F;
    localparam int SQ_STEPS  = (W + F + 1) / 2;
    localparam int SQ_XW     = 2 * SQ_STEPS;
    localparam int IN_BITS   = 32;
    localparam int CFG_BITS  = 64;
    localparam int T_BITS    = 31;
    localparam int IDX_BITS  = 3;

    localparam logic [IDX_BITS-1:0] REG_AB   = IDX_BITS'(0);
    localparam logic [IDX_BITS-1:0] REG_CD   = IDX_BITS'(1);
    localparam logic [IDX_BITS-1:0] REG_EF   = IDX_BITS'(2);
    localparam logic [IDX_BITS-1:0] REG_GH   = IDX_BITS'(3);
    localparam logic [IDX_BITS-1:0] REG_IJ   = IDX_BITS'(4);
    localparam logic [IDX_BITS-1:0] REG_MINT = IDX_BITS'(5);

    localparam logic [T_BITS-1:0] MIN_T_RESET = T_BITS'(66);

    typedef logic signed [W-1:0]    t_word;
    typedef logic [W-1:0]           t_umag;
    typedef logic [PW-1:0]          t_prod;
    typedef logic signed [WIDE-1:0] t_wide;

    localparam t_wide WMAX_W = (t_wide'(1) <<< (W - 1)) - t_wide'(1);
    localparam t_wide WMIN_W = -WMAX_W - t_wide'(1);
    localparam t_wide TMAX_W = (t_wide'(1) <<< T_BITS) - t_wide'(1);

    localparam logic [PW:0] P_RND     = (PW + 1)'(1) << (F - 1);
    localparam logic [PW:0] P_LIM_NEG = (PW + 1)'(1) << (W - 1);
    localparam logic [PW:0] P_LIM_POS = P_LIM_NEG - (PW + 1)'(1);

    localparam logic [DIV_STEPS-1:0] D_LIM_NEG = DIV_STEPS'(1) << (W - 1);
    localparam logic [DIV_STEPS-1:0] D_LIM_POS = D_LIM_NEG - DIV_STEPS'(1);

    typedef struct packed {
        t_word a, b, c, d, e, f, g, h, i, j;
        t_word b2, c2, d2, f2, g2, i2;
    } t_coef;

    typedef struct packed {
        t_word px, py, pz, dx, dy, dz;
    } t_ray;

    typedef struct packed {
        logic lin;
        logic nohit;
    } t_dside;

    typedef struct packed {
        logic  lin;
        logic  nohit;
        t_word ka;
    } t_sside;

    typedef struct packed {
        t_umag                rem;
        logic [DIV_STEPS-1:0] dq;
        t_umag                den;
        logic                 neg;
        logic                 zero;
    } t_dlane;

    typedef struct packed {
        logic [SQ_XW-1:0]    x;
        logic [SQ_STEPS+1:0] r;
        logic [SQ_STEPS-1:0] q;
    } t_sq;

    function automatic t_word sat_w(input t_wide x);
        t_word res;
        if (x > WMAX_W) begin
            res = t_word'(WMAX_W);
        end else if (x < WMIN_W) begin
            res = t_word'(WMIN_W);
        end else begin
            res = t_word'(x);
        end
        return res;
    endfunction

    function automatic t_word in_word(input logic [IN_BITS-1:0] v);
        return sat_w(t_wide'(signed'(v)));
    endfunction

    function automatic t_word qadd(input t_word x, input t_word y);
        return sat_w(t_wide'(x) + t_wide'(y));
    endfunction

    function automatic t_word qneg(input t_word x);
        return sat_w(-t_wide'(x));
    endfunction

    function automatic t_word qdbl(input t_word x);
        return sat_w(t_wide'(x) <<< 1);
    endfunction

    function automatic t_umag qmag(input t_word x);
        return x[W-1] ? t_umag'(-x) : t_umag'(x);
    endfunction

    function automatic logic lt_mt(input t_word t, input logic [T_BITS-1:0] mt);
        return t_wide'(t) < t_wide'(signed'({1'b0, mt}));
    endfunction

    // round half away from zero on the magnitude, then saturate
    function automatic t_word qmul_fin(input logic neg, input t_prod pm);
        logic [PW:0] r;
        logic [PW:0] lim;
        t_umag       m;
        r   = ({1'b0, pm} + P_RND) >> F;
        lim = neg ? P_LIM_NEG : P_LIM_POS;
        if (r > lim) begin
            r = lim;
        end
        m = r[W-1:0];
        return neg ? t_word'(-m) : t_word'(m);
    endfunction

    function automatic t_dlane div_load(input t_word num, input t_word den);
        t_dlane s;
        s.rem  = '0;
        s.dq   = {qmag(num), {F{1'b0}}};
        s.den  = qmag(den);
        s.neg  = num[W-1] ^ den[W-1];
        s.zero = (den == '0);
        return s;
    endfunction

    function automatic t_dlane div_step(input t_dlane s);
        t_dlane     n;
        logic [W:0] t;
        logic       ge;
        t    = {s.rem, s.dq[DIV_STEPS-1]};
        ge   = t >= {1'b0, s.den};
        n    = s;
        n.rem = ge ? W'(t - {1'b0, s.den}) : t[W-1:0];
        n.dq  = {s.dq[DIV_STEPS-2:0], ge};
        return n;
    endfunction

    function automatic t_word div_fin(input t_dlane s);
        logic [DIV_STEPS-1:0] lim;
        logic [DIV_STEPS-1:0] q;
        t_umag                m;
        lim = s.neg ? D_LIM_NEG : D_LIM_POS;
        q   = (s.dq > lim) ? lim : s.dq;
        m   = q[W-1:0];
        if (s.zero) begin
            m = '0;
        end
        return s.neg ? t_word'(-m) : t_word'(m);
    endfunction

    function automatic t_sq sq_load(input t_word d);
        t_sq   s;
        t_umag u;
        u   = d[W-1] ? '0 : t_umag'(d);
        s.x = SQ_XW'({u, {F{1'b0}}});
        s.r = '0;
        s.q = '0;
        return s;
    endfunction

    function automatic t_sq sq_step(input t_sq s);
        t_sq                 n;
        logic [SQ_STEPS+1:0] rr;
        logic [SQ_STEPS+1:0] trial;
        logic                ge;
        rr    = {s.r[SQ_STEPS-1:0], s.x[SQ_XW-1 -: 2]};
        trial = {s.q, 2'b01};
        ge    = rr >= trial;
        n.r   = ge ? rr - trial : rr;
        n.q   = {s.q[SQ_STEPS-2:0], ge};
        n.x   = s.x << 2;
        return n;
    endfunction

endpackage

### design/rqi_poly.sv
`timescale 1ns / 1ps
module rqi_poly (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  rqi_pkg::t_ray  i_ray,
    input  rqi_pkg::t_coef i_coef,
    output logic           o_valid,
    output rqi_pkg::t_word o_a,
    output rqi_pkg::t_word o_bh,
    output rqi_pkg::t_word o_c
);

    localparam int N1 = 18;
    localparam int N2 = 9;

    rqi_pkg::t_word x1 [N1];
    rqi_pkg::t_word y1 [N1];
    rqi_pkg::t_word x2 [N2];

    logic [5:0]     r_v;
    rqi_pkg::t_ray  r_ray1, r_ray2, r_ray3;
    logic           r_neg1 [N1];
    rqi_pkg::t_prod r_pm1  [N1];
    rqi_pkg::t_word r_m1   [N1];
    rqi_pkg::t_word r_s1   [N2];
    logic           r_neg2 [N2];
    rqi_pkg::t_prod r_pm2  [N2];
    rqi_pkg::t_word r_m2   [N2];
    rqi_pkg::t_word r_a, r_bh, r_c;

    always_comb begin
        x1[0]  = i_coef.a;  y1[0]  = i_ray.dx;
        x1[1]  = i_coef.b2; y1[1]  = i_ray.dy;
        x1[2]  = i_coef.c2; y1[2]  = i_ray.dz;
        x1[3]  = i_coef.e;  y1[3]  = i_ray.dy;
        x1[4]  = i_coef.f2; y1[4]  = i_ray.dz;
        x1[5]  = i_coef.h;  y1[5]  = i_ray.dz;
        x1[6]  = i_coef.a;  y1[6]  = i_ray.px;
        x1[7]  = i_coef.b;  y1[7]  = i_ray.py;
        x1[8]  = i_coef.c;  y1[8]  = i_ray.pz;
        x1[9]  = i_coef.b;  y1[9]  = i_ray.px;
        x1[10] = i_coef.e;  y1[10] = i_ray.py;
        x1[11] = i_coef.f;  y1[11] = i_ray.pz;
        x1[12] = i_coef.c;  y1[12] = i_ray.px;
        x1[13] = i_coef.f;  y1[13] = i_ray.py;
        x1[14] = i_coef.h;  y1[14] = i_ray.pz;
        x1[15] = i_coef.b2; y1[15] = i_ray.py;
        x1[16] = i_coef.c2; y1[16] = i_ray.pz;
        x1[17] = i_coef.f2; y1[17] = i_ray.pz;
    end

    always_comb begin
        x2[0] = r_ray3.dx;
        x2[1] = r_ray3.dy;
        x2[2] = r_ray3.dz;
        x2[3] = r_ray3.dx;
        x2[4] = r_ray3.dy;
        x2[5] = r_ray3.dz;
        x2[6] = r_ray3.px;
        x2[7] = r_ray3.py;
        x2[8] = r_ray3.pz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ray1 <= i_ray;
            r_ray2 <= r_ray1;
            r_ray3 <= r_ray2;
            for (int k = 0; k < N1; k++) begin
                r_neg1[k] <= x1[k][rqi_pkg::W-1] ^ y1[k][rqi_pkg::W-1];
                r_pm1[k]  <= rqi_pkg::qmag(x1[k]) * rqi_pkg::qmag(y1[k]);
                r_m1[k]   <= rqi_pkg::qmul_fin(r_neg1[k], r_pm1[k]);
            end
            r_s1[0] <= rqi_pkg::qadd(rqi_pkg::qadd(r_m1[0], r_m1[1]), r_m1[2]);
            r_s1[1] <= rqi_pkg::qadd(r_m1[3], r_m1[4]);
            r_s1[2] <= r_m1[5];
            r_s1[3] <= rqi_pkg::qadd(rqi_pkg::qadd(rqi_pkg::qadd(r_m1[6], r_m1[7]),
                       r_m1[8]), i_coef.d);
            r_s1[4] <= rqi_pkg::qadd(rqi_pkg::qadd(rqi_pkg::qadd(r_m1[9], r_m1[10]),
                       r_m1[11]), i_coef.g);
            r_s1[5] <= rqi_pkg::qadd(rqi_pkg::qadd(rqi_pkg::qadd(r_m1[12], r_m1[13]),
                       r_m1[14]), i_coef.i);
            r_s1[6] <= rqi_pkg::qadd(rqi_pkg::qadd(rqi_pkg::qadd(r_m1[6], r_m1[15]),
                       r_m1[16]), i_coef.d2);
            r_s1[7] <= rqi_pkg::qadd(rqi_pkg::qadd(r_m1[10], r_m1[17]), i_coef.g2);
            r_s1[8] <= rqi_pkg::qadd(r_m1[14], i_coef.i2);
            for (int k = 0; k < N2; k++) begin
                r_neg2[k] <= x2[k][rqi_pkg::W-1] ^ r_s1[k][rqi_pkg::W-1];
                r_pm2[k]  <= rqi_pkg::qmag(x2[k]) * rqi_pkg::qmag(r_s1[k]);
                r_m2[k]   <= rqi_pkg::qmul_fin(r_neg2[k], r_pm2[k]);
            end
            r_a  <= rqi_pkg::qadd(rqi_pkg::qadd(r_m2[0], r_m2[1]), r_m2[2]);
            r_bh <= rqi_pkg::qadd(rqi_pkg::qadd(r_m2[3], r_m2[4]), r_m2[5]);
            r_c  <= rqi_pkg::qadd(rqi_pkg::qadd(rqi_pkg::qadd(r_m2[6], r_m2[7]),
                    r_m2[8]), i_coef.j);
        end
    end

    assign o_valid = r_v[5];
    assign o_a     = r_a;
    assign o_bh    = r_bh;
    assign o_c     = r_c;

endmodule

### design/rqi_div.sv
`timescale 1ns / 1ps
module rqi_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  rqi_pkg::t_word   i_num_a,
    input  rqi_pkg::t_word   i_den_a,
    input  rqi_pkg::t_word   i_num_b,
    input  rqi_pkg::t_word   i_den_b,
    input  rqi_pkg::t_dside  i_side,
    output logic             o_valid,
    output rqi_pkg::t_word   o_q_a,
    output rqi_pkg::t_word   o_q_b,
    output rqi_pkg::t_dside  o_side
);

    localparam int S = rqi_pkg::DIV_STEPS;

    logic [S:0]      r_v;
    rqi_pkg::t_dlane r_st [0:S][0:1];
    rqi_pkg::t_dside r_sb [0:S];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[S-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0][0] <= rqi_pkg::div_load(i_num_a, i_den_a);
            r_st[0][1] <= rqi_pkg::div_load(i_num_b, i_den_b);
            r_sb[0]    <= i_side;
            for (int k = 1; k <= S; k++) begin
                r_st[k][0] <= rqi_pkg::div_step(r_st[k-1][0]);
                r_st[k][1] <= rqi_pkg::div_step(r_st[k-1][1]);
                r_sb[k]    <= r_sb[k-1];
            end
        end
    end

    assign o_valid = r_v[S];
    assign o_q_a   = rqi_pkg::div_fin(r_st[S][0]);
    assign o_q_b   = rqi_pkg::div_fin(r_st[S][1]);
    assign o_side  = r_sb[S];

endmodule

### design/rqi_sqrt.sv
`timescale 1ns / 1ps
module rqi_sqrt (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  rqi_pkg::t_word  i_d,
    input  rqi_pkg::t_sside i_side,
    output logic            o_valid,
    output rqi_pkg::t_word  o_s,
    output rqi_pkg::t_sside o_side
);

    localparam int S = rqi_pkg::SQ_STEPS;

    logic [S:0]      r_v;
    rqi_pkg::t_sq    r_st [0:S];
    rqi_pkg::t_sside r_sb [0:S];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[S-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0] <= rqi_pkg::sq_load(i_d);
            r_sb[0] <= i_side;
            for (int k = 1; k <= S; k++) begin
                r_st[k] <= rqi_pkg::sq_step(r_st[k-1]);
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    assign o_valid = r_v[S];
    assign o_s     = rqi_pkg::W'(r_st[S].q);
    assign o_side  = r_sb[S];

endmodule

### design/ray_quadric_intersect_top.sv
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// ray in    i_valid / o_ready      i_ray_pos_x..z, i_ray_dir_x..z
// result    o_valid / i_ready      o_hit, o_t_hit, o_inside_res
// config    i_cfg_we               i_cfg_index, i_cfg_data
//
// One ray per cycle while no held result stalls the pipeline, through the
// 48-step two-lane divider and the 24-step square root pipelines.
// Reset clears all stage valids and loads the coefficient registers with
// zero and min_t with 66; no clearing pass.
// A result held at the output stalls every stage together; nothing is lost.
module ray_quadric_intersect_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [31:0]                  i_ray_pos_x,
    input  logic signed [31:0]                  i_ray_pos_y,
    input  logic signed [31:0]                  i_ray_pos_z,
    input  logic signed [31:0]                  i_ray_dir_x,
    input  logic signed [31:0]                  i_ray_dir_y,
    input  logic signed [31:0]                  i_ray_dir_z,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_hit,
    output logic [rqi_pkg::T_BITS-1:0]          o_t_hit,
    output logic                                o_inside_res,
    input  logic                                i_cfg_we,
    input  logic [rqi_pkg::IDX_BITS-1:0]        i_cfg_index,
    input  logic [rqi_pkg::CFG_BITS-1:0]        i_cfg_data
);

    logic [rqi_pkg::CFG_BITS-1:0] r_ab, r_cd, r_ef, r_gh, r_ij;
    logic [rqi_pkg::T_BITS-1:0]   r_mt;

    rqi_pkg::t_coef  coef;
    rqi_pkg::t_ray   ray;
    logic            en;

    logic            pv;
    rqi_pkg::t_word  pa, pbh, pc;

    rqi_pkg::t_word  abs_a;
    logic            lin;

    logic            r_dv;
    rqi_pkg::t_word  r_num1, r_den1, r_num2, r_den2;
    rqi_pkg::t_dside r_dsd;

    logic            dv;
    rqi_pkg::t_word  dq1, dq2;
    rqi_pkg::t_dside dsd;

    logic            r_kv;
    rqi_pkg::t_word  r_q1, r_q2;
    rqi_pkg::t_dside r_ksd;

    logic            r_mv;
    rqi_pkg::t_prod  r_mpm;
    rqi_pkg::t_word  r_ka, r_kb;
    rqi_pkg::t_dside r_msd;

    rqi_pkg::t_word  disc;
    rqi_pkg::t_sside xsd;

    logic            r_xv;
    rqi_pkg::t_word  r_disc;
    rqi_pkg::t_sside r_xsd;

    logic            sv;
    rqi_pkg::t_word  ss;
    rqi_pkg::t_sside ssd;

    rqi_pkg::t_word  t1, t2, tsel;
    rqi_pkg::t_wide  tw;
    logic            n_hit, n_inside;
    logic [rqi_pkg::T_BITS-1:0] n_t;

    logic            r_out_valid;
    logic            r_hit, r_inside;
    logic [rqi_pkg::T_BITS-1:0] r_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ab <= '0;
            r_cd <= '0;
            r_ef <= '0;
            r_gh <= '0;
            r_ij <= '0;
            r_mt <= rqi_pkg::MIN_T_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rqi_pkg::REG_AB:   r_ab <= i_cfg_data;
                rqi_pkg::REG_CD:   r_cd <= i_cfg_data;
                rqi_pkg::REG_EF:   r_ef <= i_cfg_data;
                rqi_pkg::REG_GH:   r_gh <= i_cfg_data;
                rqi_pkg::REG_IJ:   r_ij <= i_cfg_data;
                rqi_pkg::REG_MINT: r_mt <= i_cfg_data[rqi_pkg::T_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        coef.a  = rqi_pkg::in_word(r_ab[31:0]);
        coef.b  = rqi_pkg::in_word(r_ab[63:32]);
        coef.c  = rqi_pkg::in_word(r_cd[31:0]);
        coef.d  = rqi_pkg::in_word(r_cd[63:32]);
        coef.e  = rqi_pkg::in_word(r_ef[31:0]);
        coef.f  = rqi_pkg::in_word(r_ef[63:32]);
        coef.g  = rqi_pkg::in_word(r_gh[31:0]);
        coef.h  = rqi_pkg::in_word(r_gh[63:32]);
        coef.i  = rqi_pkg::in_word(r_ij[31:0]);
        coef.j  = rqi_pkg::in_word(r_ij[63:32]);
        coef.b2 = rqi_pkg::qdbl(coef.b);
        coef.c2 = rqi_pkg::qdbl(coef.c);
        coef.d2 = rqi_pkg::qdbl(coef.d);
        coef.f2 = rqi_pkg::qdbl(coef.f);
        coef.g2 = rqi_pkg::qdbl(coef.g);
        coef.i2 = rqi_pkg::qdbl(coef.i);
        ray.px  = rqi_pkg::in_word(i_ray_pos_x);
        ray.py  = rqi_pkg::in_word(i_ray_pos_y);
        ray.pz  = rqi_pkg::in_word(i_ray_pos_z);
        ray.dx  = rqi_pkg::in_word(i_ray_dir_x);
        ray.dy  = rqi_pkg::in_word(i_ray_dir_y);
        ray.dz  = rqi_pkg::in_word(i_ray_dir_z);
    end

    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;

    rqi_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_ray   (ray),
        .i_coef  (coef),
        .o_valid (pv),
        .o_a     (pa),
        .o_bh    (pbh),
        .o_c     (pc)
    );

    // pick linear or quadratic solve
    assign abs_a = pa[rqi_pkg::W-1] ? rqi_pkg::qneg(pa) : pa;
    assign lin   = rqi_pkg::lt_mt(abs_a, r_mt) || (pa == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
            r_kv <= 1'b0;
            r_mv <= 1'b0;
            r_xv <= 1'b0;
        end else if (en) begin
            r_dv <= pv;
            r_kv <= dv;
            r_mv <= r_kv;
            r_xv <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num1      <= lin ? rqi_pkg::qneg(pc) : rqi_pkg::qneg(pbh);
            r_den1      <= lin ? rqi_pkg::qdbl(pbh) : pa;
            r_num2      <= pc;
            r_den2      <= pa;
            r_dsd.lin   <= lin;
            r_dsd.nohit <= lin && (pbh == '0);
        end
    end

    rqi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_dv),
        .i_num_a (r_num1),
        .i_den_a (r_den1),
        .i_num_b (r_num2),
        .i_den_b (r_den2),
        .i_side  (r_dsd),
        .o_valid (dv),
        .o_q_a   (dq1),
        .o_q_b   (dq2),
        .o_side  (dsd)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q1  <= dq1;
            r_q2  <= dq2;
            r_ksd <= dsd;
            r_mpm <= rqi_pkg::qmag(r_q1) * rqi_pkg::qmag(r_q1);
            r_ka  <= r_q1;
            r_kb  <= r_q2;
            r_msd <= r_ksd;
        end
    end

    always_comb begin
        disc      = rqi_pkg::qadd(rqi_pkg::qmul_fin(1'b0, r_mpm), rqi_pkg::qneg(r_kb));
        xsd.lin   = r_msd.lin;
        xsd.ka    = r_ka;
        xsd.nohit = r_msd.nohit ||
                    (r_msd.lin ? rqi_pkg::lt_mt(r_ka, r_mt) : rqi_pkg::lt_mt(disc, r_mt));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_disc <= disc;
            r_xsd  <= xsd;
        end
    end

    rqi_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_xv),
        .i_d     (r_disc),
        .i_side  (r_xsd),
        .o_valid (sv),
        .o_s     (ss),
        .o_side  (ssd)
    );

    // near root first, far root marks an inside start
    always_comb begin
        t1       = rqi_pkg::qadd(ssd.ka, rqi_pkg::qneg(ss));
        t2       = rqi_pkg::qadd(ssd.ka, ss);
        tsel     = ssd.ka;
        n_hit    = !ssd.nohit;
        n_inside = 1'b0;
        if (!ssd.lin && !ssd.nohit) begin
            if (!rqi_pkg::lt_mt(t1, r_mt)) begin
                tsel = t1;
            end else if (!rqi_pkg::lt_mt(t2, r_mt)) begin
                tsel     = t2;
                n_inside = 1'b1;
            end else begin
                n_hit = 1'b0;
            end
        end
        tw  = rqi_pkg::t_wide'(tsel);
        n_t = (tw > rqi_pkg::TMAX_W) ? '1 : tw[rqi_pkg::T_BITS-1:0];
        if (!n_hit) begin
            n_t = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= sv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit    <= n_hit;
            r_t      <= n_t;
            r_inside <= n_inside;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hit        = r_hit;
    assign o_t_hit      = r_t;
    assign o_inside_res = r_inside;

endmodule

### design/rqi_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rqi_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic                       i_hit,
    input logic [rqi_pkg::T_BITS-1:0] i_t_hit,
    input logic                       i_inside_res
);

    `RQI_ASSERT_IMP(a_miss_clean, i_clk, i_rst_n, i_out_valid && !i_hit, i_t_hit == 0 && !i_inside_res, "miss item carries distance or inside flag")
    `RQI_ASSERT_IMP(a_inside_hit, i_clk, i_rst_n, i_out_valid && i_inside_res, i_hit, "inside flag without hit")
    `RQI_ASSERT_IMP(a_ready_empty, i_clk, i_rst_n, !i_out_valid || i_out_ready, i_in_ready, "input stalled while output stage frees")
    `RQI_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_hit) && $stable(i_t_hit) && $stable(i_inside_res), "stalled result item changed")

endmodule

bind ray_quadric_intersect_top rqi_checker u_rqi_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_valid),
    .i_in_ready   (o_ready),
    .i_out_valid  (o_valid),
    .i_out_ready  (i_ready),
    .i_hit        (o_hit),
    .i_t_hit      (o_t_hit),
    .i_inside_res (o_inside_res)
);
